### sv/fmf_pkg.sv
// fmf_pkg: shared types and constants of the MIDI message framer.
// Holds the result kinds, framing phases, MIDI byte codes and queue entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmf_pkg;

  // Width of the reported error position
  localparam int unsigned POS_W = 16;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_SHORT      = 3'd0,
    KIND_SYSEX_BYTE = 3'd1,
    KIND_SYSEX_END  = 3'd2,
    KIND_ACCEPT     = 3'd3,
    KIND_REJECT     = 3'd4
  } kind_e;

  // Framing phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_NEED1    = 3'd1,
    PH_NEED2    = 3'd2,
    PH_SYSEX    = 3'd3,
    PH_REJECTED = 3'd4
  } phase_e;

  // Rejection codes
  localparam logic ERR_BAD_DATA   = 1'b0;
  localparam logic ERR_INCOMPLETE = 1'b1;

  // MIDI byte codes
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] QFRAME      = 8'hF1;
  localparam logic [7:0] SONG_POS    = 8'hF2;
  localparam logic [7:0] SONG_SEL    = 8'hF3;
  localparam logic [7:0] TUNE_REQ    = 8'hF6;
  localparam logic [7:0] EOX         = 8'hF7;
  localparam logic [7:0] REALTIME_LO = 8'hF8;
  localparam logic [3:0] SYSTEM_HI   = 4'hF;
  localparam logic [3:0] PROG_HI     = 4'hC;
  localparam logic [3:0] PRESS_HI    = 4'hD;

  // One result item, without its last flag
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        status;
    logic [6:0]        first;
    logic [6:0]        second;
    logic [1:0]        len;
    logic [7:0]        sysex;
    logic              err;
    logic [POS_W-1:0]  pos;
  } res_t;

  // Results caused by one byte: one or two
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

### sv/midi_message_framer.sv
// midi_message_framer: frames raw MIDI bytes into short messages, sysex bytes
// and block verdicts. A result is offered once its entry is queued. Throughput:
// one byte per cycle unless the queue is full; a byte with two results holds the
// output for both; a QUEUE_DEPTH-entry queue between framer and output absorbs it.
// Reset: asynchronous, active low; clears phase, held bytes, index and queue.
// Depends on fmf_pkg, fmf_front, fmf_queue, fmf_back.
`timescale 1ns / 1ps
`default_nettype none

module midi_message_framer #(
  parameter int unsigned INDEX_BITS  = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        block_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       status_byte_o,
  output logic [6:0]       first_data_o,
  output logic [6:0]       second_data_o,
  output logic [1:0]       msg_length_o,
  output logic [7:0]       sysex_byte_o,
  output logic             error_code_o,
  output logic [15:0]      error_position_o,
  output logic             last_result_o
);

  fmf_pkg::entry_t  push_entry, head;
  fmf_pkg::qstat_t  qstat;
  fmf_pkg::res_t    res;
  logic             take, push, pop;

  // Front accepts whenever the queue has room
  assign in_stall_o = qstat.full;
  assign take       = in_valid_i && !in_stall_o;

  fmf_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .byte_i  (byte_value_i),
    .last_i  (block_end_i),
    .entry_o (push_entry),
    .push_o  (push)
  );

  fmf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (qstat)
  );

  fmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .last_o      (last_result_o)
  );

  // Result fields
  assign kind_o           = res.kind;
  assign status_byte_o    = res.status;
  assign first_data_o     = res.first;
  assign second_data_o    = res.second;
  assign msg_length_o     = res.len;
  assign sysex_byte_o     = res.sysex;
  assign error_code_o     = res.err;
  assign error_position_o = res.pos;

  // A block verdict is always the final result of its byte
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((kind_o == fmf_pkg::KIND_ACCEPT) || (kind_o == fmf_pkg::KIND_REJECT))
    |-> last_result_o)
    else $error("block verdict not marked as final result");

  // Short messages carry a nonzero length, other kinds none
  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == fmf_pkg::KIND_SHORT) == (msg_length_o != 2'd0)))
    else $error("message length does not match result kind");

  // The queue never pushes while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("result queue overflow");

  // A stalled result item holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res) && $stable(last_result_o))
    else $error("stalled result item changed");

endmodule

`default_nettype wire

### sv/fmf_front.sv
// fmf_front: accepts raw MIDI bytes, tracks the framing phase and builds
// the zero, one or two results each byte causes. Depends on fmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmf_front #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            last_i,
  output fmf_pkg::entry_t      entry_o,
  output logic                 push_o
);

  fmf_pkg::phase_e        phase_q, phase_d, phase_step;
  logic [7:0]             status_q, status_d;
  logic [6:0]             first_q, first_d;
  logic                   three_q, three_d;
  logic [INDEX_BITS-1:0]  idx_q, idx_d;
  logic [fmf_pkg::POS_W-1:0] pos_sat;

  logic is_status, is_chan_status, is_single, is_open, open_three;
  fmf_pkg::res_t prim, endr;
  logic prim_v, end_v;

  // Position clamped to the port width
  if (INDEX_BITS > fmf_pkg::POS_W) begin : g_sat
    assign pos_sat = (|idx_q[INDEX_BITS-1:fmf_pkg::POS_W]) ? '1
                                                           : idx_q[fmf_pkg::POS_W-1:0];
  end else if (INDEX_BITS == fmf_pkg::POS_W) begin : g_eq
    assign pos_sat = idx_q;
  end else begin : g_ext
    assign pos_sat = {{(fmf_pkg::POS_W - INDEX_BITS){1'b0}}, idx_q};
  end

  // Byte decode
  assign is_status      = byte_i[7];
  assign is_chan_status = byte_i[7] && (byte_i[7:4] != fmf_pkg::SYSTEM_HI);
  assign is_single  = (byte_i >= fmf_pkg::REALTIME_LO) || (byte_i == fmf_pkg::TUNE_REQ);
  assign is_open    = is_chan_status || (byte_i inside {fmf_pkg::QFRAME, fmf_pkg::SONG_POS,
                                                         fmf_pkg::SONG_SEL});
  assign open_three = is_chan_status ?
                      !(byte_i[7:4] inside {fmf_pkg::PROG_HI, fmf_pkg::PRESS_HI})
                    : (byte_i == fmf_pkg::SONG_POS);

  // Next state
  always_comb begin
    phase_step = phase_q;
    status_d   = status_q;
    first_d    = first_q;
    three_d    = three_q;
    idx_d      = idx_q;
    phase_d    = phase_q;
    if (take_i) begin
      case (phase_q)
        fmf_pkg::PH_IDLE: begin
          if (is_open) begin
            status_d   = byte_i;
            first_d    = '0;
            three_d    = open_three;
            phase_step = fmf_pkg::PH_NEED1;
          end else if (byte_i == fmf_pkg::SYSEX_START) begin
            phase_step = fmf_pkg::PH_SYSEX;
          end
        end
        fmf_pkg::PH_NEED1: begin
          if (is_status) begin
            phase_step = fmf_pkg::PH_REJECTED;
          end else if (!three_q) begin
            phase_step = fmf_pkg::PH_IDLE;
          end else begin
            first_d    = byte_i[6:0];
            phase_step = fmf_pkg::PH_NEED2;
          end
        end
        fmf_pkg::PH_NEED2: begin
          phase_step = is_status ? fmf_pkg::PH_REJECTED : fmf_pkg::PH_IDLE;
        end
        fmf_pkg::PH_SYSEX: begin
          if (byte_i == fmf_pkg::EOX) begin
            phase_step = fmf_pkg::PH_IDLE;
          end else if (is_chan_status) begin
            // channel status ends the sysex and opens its own message
            status_d   = byte_i;
            first_d    = '0;
            three_d    = open_three;
            phase_step = fmf_pkg::PH_NEED1;
          end
        end
        default: begin
          phase_step = phase_q;
        end
      endcase
      phase_d = phase_step;
      idx_d   = (&idx_q) ? idx_q : idx_q + 1'b1;
      // block end re-arms the framer
      if (last_i) begin
        phase_d  = fmf_pkg::PH_IDLE;
        status_d = '0;
        first_d  = '0;
        three_d  = 1'b0;
        idx_d    = '0;
      end
    end
  end

  // Result building
  always_comb begin
    prim   = '0;
    prim_v = 1'b0;
    case (phase_q)
      fmf_pkg::PH_IDLE: begin
        if (is_single) begin
          prim_v      = 1'b1;
          prim.kind   = fmf_pkg::KIND_SHORT;
          prim.status = byte_i;
          prim.len    = 2'd1;
        end
      end
      fmf_pkg::PH_NEED1: begin
        if (is_status) begin
          prim_v    = 1'b1;
          prim.kind = fmf_pkg::KIND_REJECT;
          prim.err  = fmf_pkg::ERR_BAD_DATA;
          prim.pos  = pos_sat;
        end else if (!three_q) begin
          prim_v      = 1'b1;
          prim.kind   = fmf_pkg::KIND_SHORT;
          prim.status = status_q;
          prim.first  = byte_i[6:0];
          prim.len    = 2'd2;
        end
      end
      fmf_pkg::PH_NEED2: begin
        prim_v = 1'b1;
        if (is_status) begin
          prim.kind = fmf_pkg::KIND_REJECT;
          prim.err  = fmf_pkg::ERR_BAD_DATA;
          prim.pos  = pos_sat;
        end else begin
          prim.kind   = fmf_pkg::KIND_SHORT;
          prim.status = status_q;
          prim.first  = first_q;
          prim.second = byte_i[6:0];
          prim.len    = 2'd3;
        end
      end
      fmf_pkg::PH_SYSEX: begin
        prim_v = 1'b1;
        if ((byte_i == fmf_pkg::EOX) || is_chan_status) begin
          prim.kind = fmf_pkg::KIND_SYSEX_END;
        end else begin
          prim.kind  = fmf_pkg::KIND_SYSEX_BYTE;
          prim.sysex = byte_i;
        end
      end
      default: begin
        prim_v = 1'b0;
      end
    endcase

    // block end verdict, unless already rejected
    endr  = '0;
    end_v = last_i && (phase_step != fmf_pkg::PH_REJECTED);
    if (phase_step == fmf_pkg::PH_IDLE) begin
      endr.kind = fmf_pkg::KIND_ACCEPT;
    end else begin
      endr.kind = fmf_pkg::KIND_REJECT;
      endr.err  = fmf_pkg::ERR_INCOMPLETE;
      endr.pos  = pos_sat;
    end
  end

  // Pack the results of this byte
  assign push_o      = take_i && (prim_v || end_v);
  assign entry_o.two = prim_v && end_v;
  assign entry_o.r0  = prim_v ? prim : endr;
  assign entry_o.r1  = endr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= fmf_pkg::PH_IDLE;
      status_q <= '0;
      first_q  <= '0;
      three_q  <= 1'b0;
      idx_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      status_q <= status_d;
      first_q  <= first_d;
      three_q  <= three_d;
      idx_q    <= idx_d;
    end
  end

endmodule

`default_nettype wire

### sv/fmf_queue.sv
// fmf_queue: short register queue of result entries between front and back.
// Depends on fmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire fmf_pkg::entry_t  entry_i,
  input  wire logic             pop_i,
  output fmf_pkg::entry_t       head_o,
  output fmf_pkg::qstat_t       stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fmf_pkg::entry_t   mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  // Pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

### sv/fmf_back.sv
// fmf_back: hands out the queued results one item at a time on the output
// channel and retires each queue entry after its last result. Depends on fmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmf_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fmf_pkg::entry_t  head_i,
  input  wire fmf_pkg::qstat_t  stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output fmf_pkg::res_t         res_o,
  output logic                  last_o
);

  logic slot_q, slot_d;
  logic take;

  // Current result of the head entry
  assign out_valid_o = !stat_i.empty;
  assign res_o       = slot_q ? head_i.r1 : head_i.r0;
  assign last_o      = !head_i.two || slot_q;
  assign take        = out_valid_o && !out_stall_i;
  assign pop_o       = take && last_o;

  always_comb begin
    slot_d = slot_q;
    if (take) begin
      slot_d = !last_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

`default_nettype wire
